// File: rtl/dcf_pkg.sv
// Shared types, codes and helpers for the DCF77 time-code receiver.
// Used by every module of the block and by its port checker; depends on nothing.
package dcf_pkg;

  // Event kinds carried in the input word's tuser.
  typedef enum logic [1:0] {
    OP_RISE    = 2'd0,
    OP_FALL    = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_THR     = 1'b1;

  localparam logic [15:0] ONE_BIT_THR_RST = 16'd2160;
  localparam logic [15:0] SEC_THR_RST     = 16'd12960;

  // Frame layout (bit positions within the minute).
  localparam int FRAME_LEN   = 59;
  localparam logic [5:0] POS_MIN_START = 6'd21;
  localparam logic [5:0] POS_MIN_PAR   = 6'd28;
  localparam logic [5:0] POS_HOUR_START = 6'd29;
  localparam logic [5:0] POS_HOUR_PAR  = 6'd35;
  localparam logic [5:0] POS_DATE_START = 6'd36;
  localparam logic [5:0] POS_DATE_PAR  = 6'd58;
  localparam logic [5:0] BIT_CNT_MAX   = 6'd63;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // Running calendar clock.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [2:0] wday;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] min;
    logic [5:0] sec;
  } cal_t;

  // Time fields decoded from a received frame.
  typedef struct packed {
    logic [5:0] min;        // already decremented by one
    logic       load_date;  // low when the decremented minute is 59
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } dec_t;

  // Status from the frame receiver to the top level.
  typedef struct packed {
    logic       sec_tick;   // rising edge closed a second
    logic       frame_ok;   // complete frame with good parity
    dec_t       dec;
    logic [5:0] bit_cnt_nxt;
  } frm_stat_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [4:0] pad;
    logic [5:0] bits_received;
    logic       synced;
    logic [6:0] year_two_digit;
    logic [3:0] month;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } res_t;

  // BCD to binary with saturation at maxv.
  function automatic logic [7:0] bcd_sat(input logic [7:0] x, input logic [7:0] maxv);
    logic [7:0] tens;
    logic [7:0] v;
    tens = {4'd0, x[7:4]};
    v    = x - ((tens << 2) + (tens << 1));
    return (v > maxv) ? maxv : v;
  endfunction

endpackage

// File: rtl/dcf_cal_adv.sv
// One-second advance of the calendar clock, with month lengths and leap years.
// Pure combinational; depends on dcf_pkg.
module dcf_cal_adv (
  input  dcf_pkg::cal_t cur,
  output dcf_pkg::cal_t nxt
);

  logic [5:0] day_w;
  logic       new_month;

  always_comb begin
    nxt       = cur;
    day_w     = {1'b0, cur.day};
    new_month = 1'b0;
    if (cur.sec != 6'd59) begin
      nxt.sec = cur.sec + 6'd1;
    end else begin
      nxt.sec = 6'd0;
      if (cur.min != 6'd59) begin
        nxt.min = cur.min + 6'd1;
      end else begin
        nxt.min = 6'd0;
        if (cur.hour != 5'd23) begin
          nxt.hour = cur.hour + 5'd1;
        end else begin
          nxt.hour = 5'd0;
          nxt.wday = (cur.wday == 3'd7) ? 3'd1 : cur.wday + 3'd1;
          // hold the day at 31 while the month is still unknown
          if (cur.day < 5'd31) begin
            day_w = {1'b0, cur.day} + 6'd1;
          end else if (cur.month != 4'd0) begin
            day_w = 6'd32;
          end
          if (cur.month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
            new_month = (day_w == 6'd32);
          end else if (cur.month == 4'd2) begin
            new_month = (day_w == ((cur.year[1:0] == 2'd0) ? 6'd30 : 6'd29));
          end else if (cur.month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            new_month = (day_w == 6'd31);
          end
          if (new_month) begin
            day_w = 6'd1;
            if (cur.month >= 4'd12) begin
              nxt.month = 4'd1;
              nxt.year  = (cur.year == 7'd99) ? 7'd0 : cur.year + 7'd1;
            end else begin
              nxt.month = cur.month + 4'd1;
            end
          end
          nxt.day = (day_w > 6'd31) ? 5'd31 : day_w[4:0];
        end
      end
    end
  end

endmodule

// File: rtl/dcf_frame_rx.sv
// Pulse classification, frame shift store, parity tracking and tick accumulator.
// Decodes the BCD time fields of the held frame; depends on dcf_pkg.
module dcf_frame_rx #(
  parameter int FRAME_BITS = 59
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  dcf_pkg::opcode_t   op,
  input  logic [15:0]        ticks,
  input  logic [15:0]        one_thr,
  input  logic [15:0]        sec_thr,
  output dcf_pkg::frm_stat_t stat
);

  logic [dcf_pkg::FRAME_LEN-1:0] frame_r, frame_nxt;
  logic [5:0]  bit_cnt_r, bit_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        par_r, par_nxt;
  logic [2:0]  spar_r, spar_nxt;
  logic [16:0] acc_sum;
  logic [15:0] acc_sat;
  logic        sec_tick;
  logic [7:0]  min_dec;

  assign acc_sum = {1'b0, acc_r} + {1'b0, ticks};
  assign acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];

  always_comb begin
    frame_nxt   = frame_r;
    bit_cnt_nxt = bit_cnt_r;
    acc_nxt     = acc_r;
    par_nxt     = par_r;
    spar_nxt    = spar_r;
    sec_tick    = 1'b0;
    case (op)
      dcf_pkg::OP_RISE: begin
        acc_nxt = acc_sat;
        if (acc_sat > sec_thr) begin
          sec_tick = 1'b1;
          acc_nxt  = 16'd0;
        end
      end
      dcf_pkg::OP_FALL: begin
        acc_nxt = acc_sat;
        if (bit_cnt_r inside {dcf_pkg::POS_MIN_START, dcf_pkg::POS_HOUR_START,
                              dcf_pkg::POS_DATE_START}) begin
          par_nxt = 1'b0;
        end
        if (bit_cnt_r == dcf_pkg::POS_MIN_PAR)  spar_nxt[0] = par_nxt;
        if (bit_cnt_r == dcf_pkg::POS_HOUR_PAR) spar_nxt[1] = par_nxt;
        if (bit_cnt_r == dcf_pkg::POS_DATE_PAR) spar_nxt[2] = par_nxt;
        if (ticks > one_thr) begin
          // bits past the frame still flip parity but are not stored
          if (bit_cnt_r < 6'(dcf_pkg::FRAME_LEN)) frame_nxt[bit_cnt_r] = 1'b1;
          par_nxt = ~par_nxt;
        end
        if (bit_cnt_r != dcf_pkg::BIT_CNT_MAX) bit_cnt_nxt = bit_cnt_r + 6'd1;
      end
      dcf_pkg::OP_TIMEOUT: begin
        bit_cnt_nxt = 6'd0;
        frame_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      bit_cnt_r <= 6'd0;
      acc_r     <= 16'd0;
      par_r     <= 1'b0;
      spar_r    <= 3'd0;
    end else if (step) begin
      frame_r   <= frame_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      acc_r     <= acc_nxt;
      par_r     <= par_nxt;
      spar_r    <= spar_nxt;
    end
  end

  assign min_dec = dcf_pkg::bcd_sat({1'b0, frame_r[27:21]}, 8'd59);

  always_comb begin
    stat.sec_tick    = sec_tick;
    stat.frame_ok    = (bit_cnt_r == 6'(FRAME_BITS)) &&
                       (spar_r[0] == frame_r[28]) &&
                       (spar_r[1] == frame_r[35]) &&
                       (spar_r[2] == frame_r[58]);
    stat.dec.min       = (min_dec != 8'd0) ? 6'(min_dec - 8'd1) : 6'd59;
    stat.dec.load_date = (min_dec != 8'd0);
    stat.dec.hour  = 5'(dcf_pkg::bcd_sat({2'b0, frame_r[34:29]}, 8'd23));
    stat.dec.day   = 5'(dcf_pkg::bcd_sat({2'b0, frame_r[41:36]}, 8'd31));
    stat.dec.month = 4'(dcf_pkg::bcd_sat({3'b0, frame_r[49:45]}, 8'd12));
    stat.dec.year  = 7'(dcf_pkg::bcd_sat(frame_r[57:50], 8'd99));
    stat.bit_cnt_nxt = bit_cnt_nxt;
  end

endmodule

// File: rtl/dcf77_decoder_clock.sv
// DCF77 time-code receiver with a free-running calendar clock (top level).
// Instantiates dcf_frame_rx and dcf_cal_adv; depends on dcf_pkg.
//
// Each input word is one receiver event (tuser: rising edge, falling edge or
// one-second timeout) with the ticks elapsed since the previous event in tdata.
// Falling edges classify the pulse against one_bit_threshold and shift the bit
// into the minute frame; both edges accumulate ticks, and rising edges step the
// clock by one second once the sum passes second_threshold. A timeout after a
// complete frame with good parity loads the clock from the frame (second 59,
// minute minus one) and raises synced; any other timeout steps the clock one
// second and drops synced. Every event returns exactly one result word with
// the state after it. Timing: one word per clock cycle sustained while results
// are taken. A word is held in the input register, where the frame, parity and
// calendar update happens in a single pass, and then moves into the output
// register, which drives out_tvalid. The output register decouples the sides:
// while a result is stalled, one more input word is taken into the input
// register, and in_tready then stays low until the stalled result is taken.
// cfg_ready is always high; write configuration only while no event is in
// flight.
module dcf77_decoder_clock #(
  parameter int FRAME_BITS = 59
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input event channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dcf_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] elapsed_ticks
  input  logic [dcf_pkg::IN_USER_W-1:0]  in_tuser,   // [1:0] opcode
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [5:0] seconds, [11:6] minutes, [16:12] hours, [21:17] day_of_month,
  // [24:22] weekday, [28:25] month, [35:29] year_two_digit, [36] synced,
  // [42:37] bits_received, [47:43] zero
  output logic [dcf_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  // configuration
  logic [15:0] one_thr_r, sec_thr_r;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  dcf_pkg::opcode_t  s1_op_r;
  logic [15:0]       s1_ticks_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  dcf_pkg::res_t     res_r, res_nxt;

  // clock state
  dcf_pkg::cal_t     cal_r, cal_nxt, cal_adv;
  logic              sync_r, sync_nxt;

  dcf_pkg::frm_stat_t frm_stat;
  logic               advance;

  // Process the held word when the output register is free or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_thr_r <= dcf_pkg::ONE_BIT_THR_RST;
      sec_thr_r <= dcf_pkg::SEC_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcf_pkg::REG_ONE_BIT_THR: one_thr_r <= cfg_data;
        dcf_pkg::REG_SEC_THR:     sec_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dcf_frame_rx #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .op      (s1_op_r),
    .ticks   (s1_ticks_r),
    .one_thr (one_thr_r),
    .sec_thr (sec_thr_r),
    .stat    (frm_stat)
  );

  dcf_cal_adv u_adv (
    .cur (cal_r),
    .nxt (cal_adv)
  );

  // Clock update for the held event.
  always_comb begin
    cal_nxt  = cal_r;
    sync_nxt = sync_r;
    case (s1_op_r)
      dcf_pkg::OP_RISE: begin
        if (frm_stat.sec_tick) cal_nxt = cal_adv;
      end
      dcf_pkg::OP_TIMEOUT: begin
        if (frm_stat.frame_ok) begin
          // load from the frame; a wrapped minute leaves hour and date alone
          cal_nxt.min = frm_stat.dec.min;
          if (frm_stat.dec.load_date) begin
            cal_nxt.hour  = frm_stat.dec.hour;
            cal_nxt.day   = frm_stat.dec.day;
            cal_nxt.month = frm_stat.dec.month;
            cal_nxt.year  = frm_stat.dec.year;
          end
          cal_nxt.sec = 6'd59;
          sync_nxt    = 1'b1;
        end else begin
          cal_nxt  = cal_adv;
          sync_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r  <= '0;
      sync_r <= 1'b0;
    end else if (advance) begin
      cal_r  <= cal_nxt;
      sync_r <= sync_nxt;
    end
  end

  // Pack the post-event state into the result word.
  always_comb begin
    res_nxt.pad            = '0;
    res_nxt.bits_received  = frm_stat.bit_cnt_nxt;
    res_nxt.synced         = sync_nxt;
    res_nxt.year_two_digit = cal_nxt.year;
    res_nxt.month          = cal_nxt.month;
    res_nxt.weekday        = cal_nxt.wday;
    res_nxt.day_of_month   = cal_nxt.day;
    res_nxt.hours          = cal_nxt.hour;
    res_nxt.minutes        = cal_nxt.min;
    res_nxt.seconds        = cal_nxt.sec;
  end

  // Input register: load a new word whenever it is empty or draining.
  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r    <= dcf_pkg::opcode_t'(in_tuser);
      s1_ticks_r <= in_tdata;
    end
  end

  // Output register: hold a stalled word, drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

// File: rtl/dcf_checker.sv
// Port-level checker for the DCF77 receiver, bound to the top level.
// Depends on dcf_pkg and dcf77_decoder_clock.
module dcf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dcf_pkg::OUT_DATA_W-1:0] out_tdata
);

  dcf_pkg::res_t w;
  assign w = out_tdata;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a draining output side never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // seconds, minutes, hours, month and year stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (w.seconds <= 6'd59) && (w.minutes <= 6'd59) &&
                   (w.hours <= 5'd23) && (w.month <= 4'd12) &&
                   (w.year_two_digit <= 7'd99))
    else $error("clock field out of range");

endmodule

bind dcf77_decoder_clock dcf_checker u_dcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/dcf77_decoder_clock_tb.sv
// Self-checking testbench for the DCF77 time-code receiver with its calendar clock.
// Predicts every result word from its own model of frame, parity and clock state;
// depends on dcf_pkg and the dcf77_decoder_clock top level.
module dcf77_decoder_clock_tb;

  // Event code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dcf_pkg::IN_DATA_W-1:0]  in_tdata;   // [15:0] elapsed_ticks
  logic [dcf_pkg::IN_USER_W-1:0]  in_tuser;   // [1:0] opcode
  logic                           out_tvalid;
  logic                           out_tready;
  // [5:0] seconds, [11:6] minutes, [16:12] hours, [21:17] day_of_month,
  // [24:22] weekday, [28:25] month, [35:29] year_two_digit, [36] synced,
  // [42:37] bits_received, [47:43] zero
  logic [dcf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]                    cfg_data;

  dcf77_decoder_clock dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Free-running clock, period 12.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted block state: calendar, frame receiver and the two thresholds.
  // ---------------------------------------------------------------------------
  int          clk_sec, clk_min, clk_hour, clk_day, clk_wday, clk_month, clk_year;
  int          rx_bit_count;
  int          rx_tick_accum;
  logic        rx_parity;
  logic [2:0]  rx_stored_par;   // bit0 minute, bit1 hour, bit2 date
  logic [58:0] rx_frame;
  logic        clk_synced;
  int          one_bit_thr;
  int          second_thr;

  // Time words still owed by the block, oldest first.
  dcf_pkg::res_t pending_time_words[$];

  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_frames_taken;
  int          n_settings;
  int          burst_left;
  int          hold_cycles;     // receiver hold-off request, in cycles

  // Saturating add into the tick accumulator.
  function automatic void add_ticks(logic [15:0] ticks);
    int sum;
    sum = rx_tick_accum + int'(ticks);
    rx_tick_accum = (sum > 65535) ? 65535 : sum;
  endfunction

  // BCD to binary with clamping at the field's largest legal value.
  function automatic int bcd_clamped(logic [7:0] code, int maxv);
    int v;
    v = int'(code) - int'(code >> 4) * 6;
    return (v > maxv) ? maxv : v;
  endfunction

  // Advance the calendar by one second, with the leap rule on year mod 4.
  function automatic void tick_one_second();
    logic month_done;
    month_done = 1'b0;
    clk_sec++;
    if (clk_sec != 60) return;
    clk_sec = 0;
    clk_min++;
    if (clk_min != 60) return;
    clk_min = 0;
    clk_hour++;
    if (clk_hour != 24) return;
    clk_hour = 0;
    clk_wday++;
    if (clk_wday > 7) clk_wday = 1;
    if (clk_day < 31) clk_day++;
    else if (clk_month == 0) return;   // unknown month: hold the day at 31
    else clk_day = 32;
    case (clk_month)
      1, 3, 5, 7, 8, 10, 12: month_done = (clk_day == 32);
      2:                     month_done = (clk_day == ((clk_year % 4 == 0) ? 30 : 29));
      4, 6, 9, 11:           month_done = (clk_day == 31);
      default:               month_done = 1'b0;
    endcase
    if (month_done) begin
      clk_day = 1;
      if (clk_month >= 12) begin
        clk_month = 1;
        clk_year  = (clk_year + 1) % 100;
      end else begin
        clk_month++;
      end
    end
    if (clk_day > 31) clk_day = 31;
  endfunction

  // Apply one event to the predicted state and return the time word it yields.
  function automatic dcf_pkg::res_t apply_event(logic [1:0] op, logic [15:0] ticks);
    dcf_pkg::res_t w;
    int            m;
    case (op)
      dcf_pkg::OP_RISE: begin
        add_ticks(ticks);
        if (rx_tick_accum > second_thr) begin
          tick_one_second();
          rx_tick_accum = 0;
        end
      end
      dcf_pkg::OP_FALL: begin
        add_ticks(ticks);
        if (rx_bit_count == dcf_pkg::POS_MIN_START ||
            rx_bit_count == dcf_pkg::POS_HOUR_START ||
            rx_bit_count == dcf_pkg::POS_DATE_START)
          rx_parity = 1'b0;
        if (rx_bit_count == dcf_pkg::POS_MIN_PAR)  rx_stored_par[0] = rx_parity;
        if (rx_bit_count == dcf_pkg::POS_HOUR_PAR) rx_stored_par[1] = rx_parity;
        if (rx_bit_count == dcf_pkg::POS_DATE_PAR) rx_stored_par[2] = rx_parity;
        if (int'(ticks) > one_bit_thr) begin
          if (rx_bit_count < dcf_pkg::FRAME_LEN) rx_frame[rx_bit_count] = 1'b1;
          rx_parity = ~rx_parity;
        end
        if (rx_bit_count < dcf_pkg::BIT_CNT_MAX) rx_bit_count++;
      end
      dcf_pkg::OP_TIMEOUT: begin
        if (rx_bit_count == dcf_pkg::FRAME_LEN && rx_stored_par[0] == rx_frame[28] &&
            rx_stored_par[1] == rx_frame[35] && rx_stored_par[2] == rx_frame[58]) begin
          m = bcd_clamped({1'b0, rx_frame[27:21]}, 59);
          clk_min = (m > 0) ? m - 1 : 59;
          // A minute that wraps back to 59 leaves hour and date alone.
          if (clk_min != 59) begin
            clk_hour  = bcd_clamped({2'b0, rx_frame[34:29]}, 23);
            clk_day   = bcd_clamped({2'b0, rx_frame[41:36]}, 31);
            clk_month = bcd_clamped({3'b0, rx_frame[49:45]}, 12);
            clk_year  = bcd_clamped(rx_frame[57:50], 99);
          end
          clk_sec    = 59;
          clk_synced = 1'b1;
          n_frames_taken++;
        end else begin
          tick_one_second();
          clk_synced = 1'b0;
        end
        rx_bit_count = 0;
        rx_frame     = '0;
      end
      default: ;   // unused code: state unchanged
    endcase
    w                = '0;
    w.seconds        = 6'(clk_sec);
    w.minutes        = 6'(clk_min);
    w.hours          = 5'(clk_hour);
    w.day_of_month   = 5'(clk_day);
    w.weekday        = 3'(clk_wday);
    w.month          = 4'(clk_month);
    w.year_two_digit = 7'(clk_year);
    w.synced         = clk_synced;
    w.bits_received  = 6'(rx_bit_count);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender: bursts of random length, random gaps in between.
  // Entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_event(logic [1:0] op, logic [15:0] ticks);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ticks;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_time_words.push_back(apply_event(op, ticks));
    n_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_time_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both thresholds back to back; call only while the block is idle.
  task automatic write_thresholds(logic [15:0] one_thr, logic [15:0] sec_thr);
    cfg_valid <= 1'b1;
    cfg_index <= dcf_pkg::REG_ONE_BIT_THR;
    cfg_data  <= one_thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    one_bit_thr = int'(one_thr);
    @(negedge clk);
    cfg_index <= dcf_pkg::REG_SEC_THR;
    cfg_data  <= sec_thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    second_thr = int'(sec_thr);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [7:0] to_bcd(int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Build a minute frame from BCD codes with random filler and correct parity.
  function automatic logic [63:0] make_frame(logic [7:0] mn, logic [7:0] hr, logic [7:0] dy,
                                             logic [7:0] mo, logic [7:0] yr);
    logic [63:0] f;
    f        = {$urandom, $urandom};
    f[27:21] = mn[6:0];
    f[34:29] = hr[5:0];
    f[41:36] = dy[5:0];
    f[44:42] = 3'($urandom_range(7, 1));
    f[49:45] = mo[4:0];
    f[57:50] = yr;
    f[28]    = ^f[27:21];
    f[35]    = ^f[34:29];
    f[58]    = ^f[57:36];
    return f;
  endfunction

  // Pulse width that the block should classify as the given bit.
  function automatic logic [15:0] pulse_ticks(logic one);
    if (one && one_bit_thr < 65535) return 16'($urandom_range(65535, one_bit_thr + 1));
    return 16'($urandom_range(one_bit_thr, 0));
  endfunction

  // Send nbits pulses, each a falling edge with an occasional rising edge
  // ahead of it, and close the minute with a timeout.
  task automatic send_frame(logic [63:0] f, int nbits);
    logic [15:0] gap_ticks;
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(3, 0) == 0) begin
        gap_ticks = ($urandom_range(7, 0) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(15000, 0));
        send_event(dcf_pkg::OP_RISE, gap_ticks);
      end
      send_event(dcf_pkg::OP_FALL, pulse_ticks(f[i % 64]));
    end
    send_event(dcf_pkg::OP_TIMEOUT, 16'($urandom));
  endtask

  // Load a frame, then step 61 seconds so the clock crosses midnight.
  task automatic load_and_cross_midnight(logic [63:0] f);
    send_frame(f, dcf_pkg::FRAME_LEN);
    repeat (61) send_event(dcf_pkg::OP_TIMEOUT, 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Threshold boundaries, tick extremes, accumulator saturation, ignored codes.
  task automatic test_event_extremes();
    send_event(OP_UNUSED,            16'h0000);   // reports the reset state
    send_event(dcf_pkg::OP_RISE,     16'd12960);  // equal to threshold: no second
    send_event(dcf_pkg::OP_RISE,     16'd1);      // one past: add a second
    send_event(dcf_pkg::OP_FALL,     16'd2160);   // equal to threshold: zero bit
    send_event(dcf_pkg::OP_FALL,     16'd2161);   // one past: one bit
    send_event(dcf_pkg::OP_FALL,     16'h0000);
    send_event(dcf_pkg::OP_FALL,     16'hFFFF);   // accumulator saturates
    send_event(dcf_pkg::OP_RISE,     16'hFFFF);
    send_event(dcf_pkg::OP_RISE,     16'h0000);
    send_event(dcf_pkg::OP_TIMEOUT,  16'hFFFF);   // ticks ignored on a timeout
    send_event(dcf_pkg::OP_TIMEOUT,  16'h0000);
    send_event(OP_UNUSED,            16'hFFFF);
    send_event(OP_UNUSED,            16'($urandom));
  endtask

  // Overlong frame: bit count saturates, bits past the frame only flip parity.
  task automatic test_bit_count_saturation();
    for (int i = 0; i < 66; i++)
      send_event(dcf_pkg::OP_FALL, (i % 3 == 0) ? 16'hFFFF : 16'h0000);
    send_event(dcf_pkg::OP_TIMEOUT, 16'h0000);
  endtask

  // Frame loads and calendar rollovers: year end, leap day, common February,
  // unknown month, minute zero, invalid BCD.
  task automatic test_calendar_rollovers();
    load_and_cross_midnight(make_frame(to_bcd(59), to_bcd(23), to_bcd(31), to_bcd(12),
                                       to_bcd(99)));
    load_and_cross_midnight(make_frame(to_bcd(59), to_bcd(23), to_bcd(28), to_bcd(2),
                                       to_bcd(24)));
    load_and_cross_midnight(make_frame(to_bcd(59), to_bcd(23), to_bcd(28), to_bcd(2),
                                       to_bcd(23)));
    // Month zero: the day stays at 31.
    load_and_cross_midnight(make_frame(to_bcd(59), to_bcd(23), to_bcd(31), to_bcd(0),
                                       to_bcd(50)));
    // Minute zero decrements to 59 and keeps the date.
    send_frame(make_frame(to_bcd(0), to_bcd(5), to_bcd(9), to_bcd(3), to_bcd(11)),
               dcf_pkg::FRAME_LEN);
    // All-ones BCD clamps every field.
    send_frame(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), dcf_pkg::FRAME_LEN);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise.
  task automatic test_random_traffic(int n_items);
    int          stop_at;
    int          pick;
    logic [63:0] f;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
        if ($urandom_range(7, 0) == 0)
          f = make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        else
          f = make_frame(to_bcd($urandom_range(59, 0)), to_bcd($urandom_range(23, 0)),
                         to_bcd($urandom_range(31, 1)), to_bcd($urandom_range(12, 1)),
                         to_bcd($urandom_range(99, 0)));
        case ($urandom_range(11, 0))
          0: f[28] = ~f[28];
          1: f[35] = ~f[35];
          2: f[58] = ~f[58];
          default: ;
        endcase
        send_frame(f, dcf_pkg::FRAME_LEN);
      end else if (pick < 80) begin
        send_frame({$urandom, $urandom}, $urandom_range(64, 0));
      end else begin
        repeat ($urandom_range(12, 1))
          send_event(2'($urandom_range(3, 0)), 16'($urandom));
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering words.
  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (20) send_event(2'($urandom_range(3, 0)), 16'($urandom));
    wait_results_drained();
  endtask

  // New threshold pair, then a stretch of random traffic under it.
  task automatic test_threshold_setting(logic [15:0] one_thr, logic [15:0] sec_thr,
                                        int n_items);
    wait_results_drained();
    write_thresholds(one_thr, sec_thr);
    test_random_traffic(n_items);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted word with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    dcf_pkg::res_t got;
    dcf_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_time_words.size() == 0) begin
        $error("result word with no expectation waiting: %h", out_tdata);
        n_errors++;
      end else begin
        want = pending_time_words.pop_front();
        check_field("seconds",        int'(want.seconds),        int'(got.seconds));
        check_field("minutes",        int'(want.minutes),        int'(got.minutes));
        check_field("hours",          int'(want.hours),          int'(got.hours));
        check_field("day_of_month",   int'(want.day_of_month),   int'(got.day_of_month));
        check_field("weekday",        int'(want.weekday),        int'(got.weekday));
        check_field("month",          int'(want.month),          int'(got.month));
        check_field("year_two_digit", int'(want.year_two_digit), int'(got.year_two_digit));
        check_field("synced",         int'(want.synced),         int'(got.synced));
        check_field("bits_received",  int'(want.bits_received),  int'(got.bits_received));
        check_field("pad",            int'(want.pad),            int'(got.pad));
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall pattern changes at random; a hold-off request
  // (hold_cycles) forces ready low, then sets it high again.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int mode_left;
    int phase;
    out_tready = 1'b0;
    mode       = 0;
    mode_left  = 0;
    phase      = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3, 0);
          mode_left = $urandom_range(400, 32);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(1, 0));
          2:       out_tready <= (phase % 5 != 0);
          default: out_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    #(12 * 2000000);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Predicted state after reset.
    clk_sec = 0; clk_min = 0; clk_hour = 0; clk_day = 0;
    clk_wday = 0; clk_month = 0; clk_year = 0;
    rx_bit_count   = 0;
    rx_tick_accum  = 0;
    rx_parity      = 1'b0;
    rx_stored_par  = '0;
    rx_frame       = '0;
    clk_synced     = 1'b0;
    one_bit_thr    = int'(dcf_pkg::ONE_BIT_THR_RST);
    second_thr     = int'(dcf_pkg::SEC_THR_RST);
    n_errors       = 0;
    n_sent         = 0;
    n_checked      = 0;
    n_frames_taken = 0;
    n_settings     = 0;
    burst_left     = 0;
    hold_cycles    = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed checks run on the reset thresholds.
    test_event_extremes();
    test_bit_count_saturation();
    test_calendar_rollovers();
    test_backpressure();

    // Random traffic across threshold settings, extremes included.
    test_threshold_setting(16'd0,     16'd0,     30);
    test_threshold_setting(16'hFFFF,  16'hFFFF,  30);
    test_threshold_setting(16'd2160,  16'd12960, 30);
    test_backpressure();
    test_threshold_setting(16'd1,     16'd65534, 30);
    test_threshold_setting(16'($urandom_range(6000, 500)), 16'($urandom), 30);

    wait_results_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d event words and checked %0d result words, %0d frames loaded",
             n_sent, n_checked, n_frames_taken);
    $display("across %0d threshold settings with random stalls on both sides", n_settings);
    if (n_errors == 0 && pending_time_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
